### sv/hall_tachometer_top_defines.svh
// Assertion macros shared by the tachometer checker.
`ifndef HALL_TACHOMETER_TOP_DEFINES_SVH
`define HALL_TACHOMETER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define HTACH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define HTACH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/htach_pkg.sv
// Shared constants and types of the Hall tachometer.
package htach_pkg;

  localparam int unsigned TIME_W     = 64;
  localparam int unsigned RAW_W      = 12;
  localparam int unsigned MIN_W      = 20;
  localparam int unsigned TO_MS_W    = 16;
  localparam int unsigned TO_US_W    = 26;
  localparam int unsigned PPR_W      = 8;
  localparam int unsigned STAT_W     = 16;
  localparam int unsigned PERIOD_W   = 32;
  localparam int unsigned TURN_W     = 32;
  localparam int unsigned RPM_W      = 26;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned DIV_W      = PERIOD_W + PPR_W;

  // Digit-serial subtractor geometry.
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_DIGITS = TIME_W / DIGIT_W;
  localparam int unsigned GAP_CNT_W  = $clog2(NUM_DIGITS);
  localparam int unsigned LO_DIGITS  = PERIOD_W / DIGIT_W;
  localparam int unsigned TO_SR_W    = ((TO_US_W + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
  localparam int unsigned MIN_SR_W   = ((MIN_W + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;

  // Bit-serial divider geometry.
  localparam int unsigned DIV_CNT_W  = $clog2(RPM_W);

  localparam logic [RPM_W-1:0]   RPM_NUMERATOR = RPM_W'(60000000);
  localparam logic [9:0]         US_PER_MS     = 10'd1000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TH_HIGH  = 3'd0,
    REG_TH_LOW   = 3'd1,
    REG_MIN_SP   = 3'd2,
    REG_TIMEOUT  = 3'd3,
    REG_PPR      = 3'd4,
    REG_STAT_RPM = 3'd5
  } htach_reg_e;

  // Status of the gap unit after a full pass over the timestamp.
  typedef struct packed {
    logic                done;
    logic                gt_timeout;
    logic                lt_min;
    logic [PERIOD_W-1:0] gap_lo;
  } htach_gap_t;

endpackage

### sv/htach_gap_serial.sv
// Digit-serial timestamp subtractor with serial magnitude compares.
module htach_gap_serial (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [htach_pkg::TIME_W-1:0]     now_i,
  input  logic [htach_pkg::TIME_W-1:0]     last_i,
  input  logic [htach_pkg::TO_US_W-1:0]    timeout_us_i,
  input  logic [htach_pkg::MIN_W-1:0]      min_sp_i,
  output htach_pkg::htach_gap_t            gap_o
);
  import htach_pkg::*;

  logic [TIME_W-1:0]    now_q, last_q;
  logic [TO_SR_W-1:0]   to_q;
  logic [MIN_SR_W-1:0]  min_q;
  logic [PERIOD_W-1:0]  gap_q;
  logic                 borrow_q, gt_q, lt_q;
  logic                 busy_q, done_q;
  logic [GAP_CNT_W-1:0] cnt_q;

  logic [DIGIT_W:0]     diff;
  logic [DIGIT_W-1:0]   g, dt, dm;

  always_comb begin
    diff = {1'b0, now_q[DIGIT_W-1:0]} - {1'b0, last_q[DIGIT_W-1:0]}
         - {{DIGIT_W{1'b0}}, borrow_q};
    g    = diff[DIGIT_W-1:0];
    dt   = to_q[DIGIT_W-1:0];
    dm   = min_q[DIGIT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == GAP_CNT_W'(NUM_DIGITS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      now_q    <= now_i;
      last_q   <= last_i;
      to_q     <= TO_SR_W'(timeout_us_i);
      min_q    <= MIN_SR_W'(min_sp_i);
      borrow_q <= 1'b0;
      gt_q     <= 1'b0;
      lt_q     <= 1'b0;
    end else if (busy_q) begin
      now_q    <= {{DIGIT_W{1'b0}}, now_q[TIME_W-1:DIGIT_W]};
      last_q   <= {{DIGIT_W{1'b0}}, last_q[TIME_W-1:DIGIT_W]};
      to_q     <= {{DIGIT_W{1'b0}}, to_q[TO_SR_W-1:DIGIT_W]};
      min_q    <= {{DIGIT_W{1'b0}}, min_q[MIN_SR_W-1:DIGIT_W]};
      borrow_q <= diff[DIGIT_W];
      // A higher digit overrides the verdict of the lower ones.
      gt_q     <= (g > dt) | ((g == dt) & gt_q);
      lt_q     <= (g < dm) | ((g == dm) & lt_q);
      if (cnt_q < GAP_CNT_W'(LO_DIGITS)) begin
        gap_q <= {g, gap_q[PERIOD_W-1:DIGIT_W]};
      end
    end
  end

  assign gap_o.done       = done_q;
  assign gap_o.gt_timeout = gt_q;
  assign gap_o.lt_min     = lt_q;
  assign gap_o.gap_lo     = gap_q;

endmodule

### sv/htach_div_serial.sv
// Bit-serial restoring divider for the constant rpm numerator.
module htach_div_serial (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [htach_pkg::DIV_W-1:0]    divisor_i,
  output logic                           done_o,
  output logic [htach_pkg::RPM_W-1:0]    quot_o
);
  import htach_pkg::*;

  logic [DIV_W-1:0]     div_q;
  logic [RPM_W-1:0]     num_q, rem_q, quot_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;

  logic [RPM_W:0]       rem_sh, rem_sub;
  logic                 ge;

  always_comb begin
    rem_sh  = {rem_q, num_q[RPM_W-1]};
    ge      = DIV_W'(rem_sh) >= div_q;
    rem_sub = rem_sh - div_q[RPM_W:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(RPM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q  <= divisor_i;
      num_q  <= RPM_NUMERATOR;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[RPM_W-2:0], 1'b0};
      rem_q  <= ge ? rem_sub[RPM_W-1:0] : rem_sh[RPM_W-1:0];
      quot_q <= {quot_q[RPM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### sv/hall_tachometer_top.sv
// Top level of the Hall tachometer: comparator, edge bookkeeping and rpm.
//
//   Channel   Direction  Handshake                  Payload
//   in        sink       in_valid_i / in_stall_o    kind_i, sample_raw_i, time_us_i
//   out       source     out_valid_o / out_stall_i  rpm_o, turns_since_reset_o,
//                                                    level_high_o, stationary_o
//   cfg       sink       cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One transaction is in flight at a time. An accepted input passes through
// ST_GAP, where the 4-bit digit-serial timestamp subtractor runs, ST_UPD,
// ST_MUL and ST_DIV, where the bit-serial divider forms one quotient bit of
// the rpm per cycle, then ST_DONE; a new input is taken only back in ST_IDLE.
// Reset is asynchronous and active low; it loads the register defaults and
// clears the comparator, edge, period and turn state.
// A finished result waits in the output register while out_stall_i is high;
// the next input is still accepted during that wait.
module hall_tachometer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [htach_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [htach_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // Input channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              kind_i,
  input  logic [htach_pkg::RAW_W-1:0]       sample_raw_i,
  input  logic [htach_pkg::TIME_W-1:0]      time_us_i,
  // Output channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [htach_pkg::RPM_W-1:0]       rpm_o,
  output logic [htach_pkg::TURN_W-1:0]      turns_since_reset_o,
  output logic                              level_high_o,
  output logic                              stationary_o
);
  import htach_pkg::*;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_GAP  = 6'b000010,
    ST_UPD  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } htach_state_e;

  htach_state_e state_q, state_d;

  // Configuration registers.
  logic [RAW_W-1:0]   th_hi_q, th_lo_q;
  logic [MIN_W-1:0]   min_sp_q;
  logic [TO_MS_W-1:0] to_ms_q;
  logic [PPR_W-1:0]   ppr_q;
  logic [STAT_W-1:0]  stat_q;

  // Architectural state.
  logic                cmp_q, edge_seen_q;
  logic [TIME_W-1:0]   last_edge_q;
  logic [PERIOD_W-1:0] period_q;
  logic [TURN_W-1:0]   turn_total_q, turn_offset_q;

  // Captured transaction and intermediate results.
  logic                kind_q;
  logic [RAW_W-1:0]    raw_q;
  logic [TIME_W-1:0]   now_q;
  logic                zero_q;

  // Output register.
  logic                out_valid_q;
  logic [RPM_W-1:0]    rpm_q;
  logic [TURN_W-1:0]   turns_q;
  logic                level_q, stat_flag_q;

  logic                in_acc, out_free;
  logic [TO_US_W-1:0]  timeout_us;
  htach_gap_t          gap;
  logic [DIV_W-1:0]    divisor;
  logic                div_start, div_done;
  logic [RPM_W-1:0]    quot;
  logic [RPM_W-1:0]    rpm_val;

  // Update decisions made once the gap is known.
  logic                rising, falling, edge_taken, timed_out;
  logic [PERIOD_W-1:0] period_new, period_eff;
  logic                edge_seen_new;

  assign in_acc     = (state_q == ST_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Timeout in microseconds; the millisecond register stays below 2^16 so the
  // product fits in 26 bits.
  assign timeout_us = {{(TO_US_W-TO_MS_W){1'b0}}, to_ms_q}
                    * {{(TO_US_W-10){1'b0}}, US_PER_MS};

  htach_gap_serial u_gap (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_acc),
    .now_i        (time_us_i),
    .last_i       (last_edge_q),
    .timeout_us_i (timeout_us),
    .min_sp_i     (min_sp_q),
    .gap_o        (gap)
  );

  // The divisor comes from the updated period, so it is formed in the cycle after
  // the state update and registered inside the divider.
  assign divisor   = {{PPR_W{1'b0}}, period_q} * {{PERIOD_W{1'b0}}, ppr_q};
  assign div_start = (state_q == ST_MUL);

  htach_div_serial u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // Rising edge: the comparator is low and the sample reaches the high
  // threshold. The first edge ever is taken with no period. An edge after a
  // gap beyond the timeout restarts with no period. Otherwise a gap below the
  // minimum spacing is bounce and is dropped.
  always_comb begin
    rising        = !kind_q && !cmp_q && (raw_q >= th_hi_q);
    falling       = !kind_q && cmp_q && (raw_q <= th_lo_q);
    edge_taken    = rising && (!edge_seen_q || gap.gt_timeout || !gap.lt_min);
    period_new    = (!edge_seen_q || gap.gt_timeout) ? '0 : gap.gap_lo;
    period_eff    = edge_taken ? period_new : period_q;
    edge_seen_new = edge_seen_q || edge_taken;
    // After an accepted edge the gap to the new edge time is zero, which never
    // exceeds the timeout.
    timed_out     = !edge_taken && gap.gt_timeout;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_GAP;
      ST_GAP:  if (gap.done) state_d = ST_UPD;
      ST_UPD:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes; indexes beyond the register list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th_hi_q  <= RAW_W'(2500);
      th_lo_q  <= RAW_W'(1500);
      min_sp_q <= MIN_W'(1000);
      to_ms_q  <= TO_MS_W'(2000);
      ppr_q    <= PPR_W'(1);
      stat_q   <= STAT_W'(50);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TH_HIGH:  th_hi_q  <= cfg_wdata_i[RAW_W-1:0];
        REG_TH_LOW:   th_lo_q  <= cfg_wdata_i[RAW_W-1:0];
        REG_MIN_SP:   min_sp_q <= cfg_wdata_i[MIN_W-1:0];
        REG_TIMEOUT:  to_ms_q  <= cfg_wdata_i[TO_MS_W-1:0];
        REG_PPR:      ppr_q    <= cfg_wdata_i[PPR_W-1:0];
        REG_STAT_RPM: stat_q   <= cfg_wdata_i[STAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Comparator, edge and turn state change in the single update cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_q         <= 1'b0;
      edge_seen_q   <= 1'b0;
      last_edge_q   <= '0;
      period_q      <= '0;
      turn_total_q  <= '0;
      turn_offset_q <= '0;
    end else if (state_q == ST_UPD) begin
      if (rising) begin
        cmp_q <= 1'b1;
      end else if (falling) begin
        cmp_q <= 1'b0;
      end
      if (edge_taken) begin
        turn_total_q <= turn_total_q + 1'b1;
        edge_seen_q  <= 1'b1;
        last_edge_q  <= now_q;
        period_q     <= period_new;
      end
      if (kind_q) begin
        turn_offset_q <= turn_total_q;
      end
    end
  end

  // Captured transaction and the forced-zero verdict for the rpm.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_i;
      raw_q  <= sample_raw_i;
      now_q  <= time_us_i;
    end
    if (state_q == ST_UPD) begin
      zero_q <= !edge_seen_new || (period_eff == '0) || timed_out || (ppr_q == '0);
    end
  end

  assign rpm_val = zero_q ? '0 : quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= (state_q == ST_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && (state_q == ST_DONE)) begin
      rpm_q       <= rpm_val;
      turns_q     <= turn_total_q - turn_offset_q;
      level_q     <= cmp_q;
      stat_flag_q <= {{(RPM_W-STAT_W){1'b0}}, stat_q} > rpm_val;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign rpm_o               = rpm_q;
  assign turns_since_reset_o = turns_q;
  assign level_high_o        = level_q;
  assign stationary_o        = stat_flag_q;

endmodule

### sv/htach_checker.sv
// Port-level checker for the Hall tachometer and its bind statement.
`include "hall_tachometer_top_defines.svh"

module htach_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [htach_pkg::RPM_W-1:0]       rpm_o,
  input logic [htach_pkg::TURN_W-1:0]      turns_since_reset_o,
  input logic                              level_high_o,
  input logic                              stationary_o
);
  import htach_pkg::*;

  // A stalled result stays put until it is taken.
  `HTACH_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(rpm_o) && $stable(turns_since_reset_o) && $stable(level_high_o) && $stable(stationary_o), "stalled result changed")

  // One transaction at a time: the block is busy right after it accepts one.
  `HTACH_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input accepted while a transaction was in flight")

  // The rpm can never exceed the numerator of the division.
  `HTACH_ASSERT_IMP(a_rpm_range, out_valid_o, rpm_o <= RPM_NUMERATOR, "rpm above its largest possible value")

endmodule

bind hall_tachometer_top htach_checker u_htach_checker (.*);
